// ===== hw/rtl/bdm_pkg.sv =====
`timescale 1ns / 1ps

package bdm_pkg;

  localparam int MAX_SIDE_LOG2 = 6;

  localparam int K_W       = 3;
  localparam int PIXEL_W   = 8;
  localparam int MODE_W    = 3;
  localparam int METRIC_W  = 28;
  localparam int CNT_W     = 2 * MAX_SIDE_LOG2;
  localparam int ABOVE_W   = 2 * MAX_SIDE_LOG2 + 1;
  localparam int SUM_W     = 2 * MAX_SIDE_LOG2 + PIXEL_W;
  localparam int SQ_W      = 2 * MAX_SIDE_LOG2 + 2 * PIXEL_W;
  localparam int CSQ_W     = 2 * MAX_SIDE_LOG2 + 2 * PIXEL_W - 1;
  localparam int NUM_W     = SQ_W + 2 * MAX_SIDE_LOG2;
  localparam int WIDE_W    = NUM_W + 8;
  localparam int V_W       = SQ_W + 16;
  localparam int ROOT_W    = V_W / 2;
  localparam int N_W       = 2 * ((1 << K_W) - 1) + 1;

  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [PIXEL_W-1:0]  CENTER_VALUE = 8'd128;
  localparam logic [METRIC_W-1:0] METRIC_MAX   = {METRIC_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUM_A = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SUM_B = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROOT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VAR   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MSE   = 3'd5;

  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_SIDE      = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PIXEL_W-1:0] threshold;
    logic [K_W-1:0]     side;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [K_W-1:0]     side;
    logic [ABOVE_W-1:0] above_count;
    logic [SUM_W-1:0]   value_sum;
    logic [SQ_W-1:0]    square_sum;
    logic [CSQ_W-1:0]   centered_square_sum;
  } block_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_VAR,
    ST_SQRT,
    ST_DONE
  } back_state_t;

  function automatic logic [K_W-1:0] eff_side(input logic [K_W-1:0] s);
    if ({1'b0, s} > (K_W + 1)'(MAX_SIDE_LOG2)) begin
      return K_W'(MAX_SIDE_LOG2);
    end
    return s;
  endfunction

  function automatic logic [METRIC_W-1:0] sat_metric(input logic [WIDE_W-1:0] v);
    if (v > WIDE_W'(METRIC_MAX)) begin
      return METRIC_MAX;
    end
    return v[METRIC_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/bdm_regs.sv =====
`timescale 1ns / 1ps

module bdm_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bdm_pkg::ADDR_W-1:0] paddr,
  input  logic [bdm_pkg::DATA_W-1:0] pwdata,
  output logic [bdm_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output bdm_pkg::cfg_t              cfg
);

  bdm_pkg::cfg_t cfg_r;
  bdm_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        bdm_pkg::REG_MODE:      cfg_nxt.mode      = pwdata[bdm_pkg::MODE_W-1:0];
        bdm_pkg::REG_THRESHOLD: cfg_nxt.threshold = pwdata[bdm_pkg::PIXEL_W-1:0];
        bdm_pkg::REG_SIDE:      cfg_nxt.side      = pwdata[bdm_pkg::K_W-1:0];
        default:                cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= bdm_pkg::MODE_MSE;
      cfg_r.threshold <= bdm_pkg::PIXEL_W'(1);
      cfg_r.side      <= bdm_pkg::K_W'(3);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      bdm_pkg::REG_MODE:      prdata = bdm_pkg::DATA_W'(cfg_r.mode);
      bdm_pkg::REG_THRESHOLD: prdata = bdm_pkg::DATA_W'(cfg_r.threshold);
      bdm_pkg::REG_SIDE:      prdata = bdm_pkg::DATA_W'(cfg_r.side);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/bdm_front.sv =====
`timescale 1ns / 1ps

module bdm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bdm_pkg::cfg_t               cfg,
  input  logic                        accept,
  input  logic [bdm_pkg::PIXEL_W-1:0] pixel,
  output logic                        q_push,
  output bdm_pkg::block_t             q_data
);

  logic [bdm_pkg::CNT_W-1:0]   count_r;
  logic [bdm_pkg::CNT_W-1:0]   count_nxt;
  logic [bdm_pkg::ABOVE_W-1:0] above_r;
  logic [bdm_pkg::ABOVE_W-1:0] above_nxt;
  logic [bdm_pkg::SUM_W-1:0]   sum_r;
  logic [bdm_pkg::SUM_W-1:0]   sum_nxt;
  logic [bdm_pkg::SQ_W-1:0]    sq_r;
  logic [bdm_pkg::SQ_W-1:0]    sq_nxt;
  logic [bdm_pkg::CSQ_W-1:0]   csq_r;
  logic [bdm_pkg::CSQ_W-1:0]   csq_nxt;

  logic [bdm_pkg::K_W-1:0]     k;
  logic [bdm_pkg::N_W-1:0]     n;
  logic [bdm_pkg::N_W-1:0]     taken;
  logic [bdm_pkg::PIXEL_W-1:0] dev;
  logic [bdm_pkg::ABOVE_W-1:0] above_add;
  logic [bdm_pkg::SUM_W-1:0]   sum_add;
  logic [bdm_pkg::SQ_W-1:0]    sq_add;
  logic [bdm_pkg::CSQ_W-1:0]   csq_add;
  logic                        block_end;

  always_comb begin
    k     = bdm_pkg::eff_side(cfg.side);
    n     = bdm_pkg::N_W'(1) << {k, 1'b0};
    taken = bdm_pkg::N_W'(count_r) + bdm_pkg::N_W'(1);
    dev   = (pixel >= bdm_pkg::CENTER_VALUE) ? pixel - bdm_pkg::CENTER_VALUE
                                             : bdm_pkg::CENTER_VALUE - pixel;

    above_add = above_r + bdm_pkg::ABOVE_W'(pixel >= cfg.threshold);
    sum_add   = sum_r + bdm_pkg::SUM_W'(pixel);
    sq_add    = sq_r + bdm_pkg::SQ_W'(pixel * pixel);
    csq_add   = csq_r + bdm_pkg::CSQ_W'(dev * dev);
    block_end = taken >= n;

    q_push                     = accept && block_end;
    q_data.mode                = cfg.mode;
    q_data.side                = k;
    q_data.above_count         = above_add;
    q_data.value_sum           = sum_add;
    q_data.square_sum          = sq_add;
    q_data.centered_square_sum = csq_add;

    count_nxt = count_r;
    above_nxt = above_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    csq_nxt   = csq_r;
    if (accept) begin
      if (block_end) begin
        count_nxt = '0;
        above_nxt = '0;
        sum_nxt   = '0;
        sq_nxt    = '0;
        csq_nxt   = '0;
      end else begin
        count_nxt = taken[bdm_pkg::CNT_W-1:0];
        above_nxt = above_add;
        sum_nxt   = sum_add;
        sq_nxt    = sq_add;
        csq_nxt   = csq_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      above_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      csq_r   <= '0;
    end else begin
      count_r <= count_nxt;
      above_r <= above_nxt;
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      csq_r   <= csq_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (count_r == '0) && (sum_r == '0) && (above_r == '0))
    else $error("block sums not cleared after block end");
`endif

endmodule

// ===== hw/rtl/bdm_queue.sv =====
`timescale 1ns / 1ps

module bdm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bdm_pkg::block_t push_data,
  output logic            full,
  input  logic            pop,
  output bdm_pkg::block_t pop_data,
  output logic            empty
);

  bdm_pkg::block_t              mem_r [bdm_pkg::Q_DEPTH];
  logic [bdm_pkg::Q_PTR_W-1:0]  wr_ptr_r;
  logic [bdm_pkg::Q_PTR_W-1:0]  wr_ptr_nxt;
  logic [bdm_pkg::Q_PTR_W-1:0]  rd_ptr_r;
  logic [bdm_pkg::Q_PTR_W-1:0]  rd_ptr_nxt;
  logic [bdm_pkg::Q_CNT_W-1:0]  count_r;
  logic [bdm_pkg::Q_CNT_W-1:0]  count_nxt;
  logic                         do_push;
  logic                         do_pop;

  assign full     = count_r == bdm_pkg::Q_CNT_W'(bdm_pkg::Q_DEPTH);
  assign empty    = count_r == '0;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == bdm_pkg::Q_PTR_W'(bdm_pkg::Q_DEPTH - 1)) ? '0
                                                                         : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == bdm_pkg::Q_PTR_W'(bdm_pkg::Q_DEPTH - 1)) ? '0
                                                                         : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bdm_pkg::Q_CNT_W'(bdm_pkg::Q_DEPTH))
    else $error("block queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("finished block pushed into a full queue");
`endif

endmodule

// ===== hw/rtl/bdm_back.sv =====
`timescale 1ns / 1ps

module bdm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  bdm_pkg::block_t              q_data,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [bdm_pkg::METRIC_W-1:0] out_metric
);

  bdm_pkg::back_state_t          state_r;
  bdm_pkg::back_state_t          state_nxt;
  bdm_pkg::block_t               blk_r;
  bdm_pkg::block_t               blk_nxt;
  logic [bdm_pkg::NUM_W-1:0]     prod_r;
  logic [bdm_pkg::NUM_W-1:0]     prod_nxt;
  logic [bdm_pkg::V_W-1:0]       v_r;
  logic [bdm_pkg::V_W-1:0]       v_nxt;
  logic [bdm_pkg::V_W-1:0]       res_r;
  logic [bdm_pkg::V_W-1:0]       res_nxt;
  logic [bdm_pkg::V_W-1:0]       bit_r;
  logic [bdm_pkg::V_W-1:0]       bit_nxt;
  logic [bdm_pkg::METRIC_W-1:0]  result_r;
  logic [bdm_pkg::METRIC_W-1:0]  result_nxt;
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  logic [bdm_pkg::METRIC_W-1:0]  out_data_r;
  logic [bdm_pkg::METRIC_W-1:0]  out_data_nxt;

  logic [bdm_pkg::V_W-1:0]       trial;
  logic [bdm_pkg::NUM_W-1:0]     num;
  logic [bdm_pkg::NUM_W-1:0]     diff;
  logic [bdm_pkg::WIDE_W-1:0]    wide;

  assign out_empty  = !out_valid_r;
  assign out_metric = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    prod_nxt      = prod_r;
    v_nxt         = v_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;

    trial = res_r + bit_r;
    num   = bdm_pkg::NUM_W'(blk_r.square_sum) << {blk_r.side, 1'b0};
    diff  = num - prod_r;
    wide  = '0;

    case (state_r)
      bdm_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          blk_nxt   = q_data;
          state_nxt = bdm_pkg::ST_CALC;
        end
      end
      bdm_pkg::ST_CALC: begin
        state_nxt = bdm_pkg::ST_DONE;
        case (blk_r.mode)
          bdm_pkg::MODE_COUNT: begin
            wide       = bdm_pkg::WIDE_W'(blk_r.above_count) << 8;
            result_nxt = bdm_pkg::sat_metric(wide);
          end
          bdm_pkg::MODE_SUM_A, bdm_pkg::MODE_SUM_B: begin
            wide       = bdm_pkg::WIDE_W'(blk_r.value_sum) << 8;
            result_nxt = bdm_pkg::sat_metric(wide);
          end
          bdm_pkg::MODE_ROOT: begin
            v_nxt     = {blk_r.square_sum, 16'd0};
            res_nxt   = '0;
            bit_nxt   = bdm_pkg::V_W'(1) << (bdm_pkg::V_W - 2);
            state_nxt = bdm_pkg::ST_SQRT;
          end
          bdm_pkg::MODE_VAR: begin
            prod_nxt  = bdm_pkg::NUM_W'(blk_r.value_sum * blk_r.value_sum);
            state_nxt = bdm_pkg::ST_VAR;
          end
          bdm_pkg::MODE_MSE: begin
            wide       = (bdm_pkg::WIDE_W'(blk_r.centered_square_sum) << 8)
                         >> {blk_r.side, 1'b0};
            result_nxt = bdm_pkg::sat_metric(wide);
          end
          default: begin
            result_nxt = '0;
          end
        endcase
      end
      bdm_pkg::ST_VAR: begin
        wide = (bdm_pkg::WIDE_W'(diff) << 8) >> {blk_r.side, 2'b00};
        if (num <= prod_r) begin
          result_nxt = '0;
        end else begin
          result_nxt = bdm_pkg::sat_metric(wide);
        end
        state_nxt = bdm_pkg::ST_DONE;
      end
      bdm_pkg::ST_SQRT: begin
        if (v_r >= trial) begin
          v_nxt   = v_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          result_nxt = bdm_pkg::sat_metric(bdm_pkg::WIDE_W'(res_nxt[bdm_pkg::ROOT_W:0]));
          state_nxt  = bdm_pkg::ST_DONE;
        end
      end
      bdm_pkg::ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_r;
          state_nxt     = bdm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bdm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    prod_r     <= prod_nxt;
    v_r        <= v_nxt;
    res_r      <= res_nxt;
    bit_r      <= bit_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bdm_pkg::ST_DONE))
    else $error("result register loaded outside the done state");
`endif

endmodule

// ===== hw/rtl/block_difference_metric_unit.sv =====
`timescale 1ns / 1ps

// Block difference metric unit. Pixels of a square block are pushed one per cycle; after
// the last pixel of the block (4^side_log2 of them) one Q8 metric appears on the result side,
// selected by metric_mode. The front accumulates at one pixel per cycle and hands each
// finished block to a two-entry queue, so input stalls only when two finished blocks wait
// for the back end. The back end handles one block at a time: count, sum and deviation modes
// finish in its calc state, variance adds a further state (one 20 by 20 multiply, then subtract
// and scale), and the root mode runs a square-root unit that settles one result bit per cycle
// over 22 steps. The result register then holds the metric until it is popped.
module block_difference_metric_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [bdm_pkg::PIXEL_W-1:0]  in_pixel,
  output logic                         empty,
  input  logic                         pop,
  output logic [bdm_pkg::METRIC_W-1:0] out_metric_q8,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdm_pkg::ADDR_W-1:0]   paddr,
  input  logic [bdm_pkg::DATA_W-1:0]   pwdata,
  output logic [bdm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  bdm_pkg::cfg_t   cfg;
  bdm_pkg::block_t push_blk;
  bdm_pkg::block_t pop_blk;
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;

  assign full = q_full;

  bdm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .accept (push && !q_full),
    .pixel  (in_pixel),
    .q_push (q_push),
    .q_data (push_blk)
  );

  bdm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_blk),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_blk),
    .empty     (q_empty)
  );

  bdm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_blk),
    .q_pop      (q_pop),
    .out_pop    (pop),
    .out_empty  (empty),
    .out_metric (out_metric_q8)
  );

endmodule
